// File: hw/rtl/crc8fr_pkg.sv
`timescale 1ns / 1ps

package crc8fr_pkg;

	localparam int MAX_PAYLOAD_DEF = 32;

	localparam int BYTE_W  = 8;
	localparam int EV_W    = 2;
	localparam int IDX_W   = 6;
	localparam int CNT_W   = 32;

	// result event codes
	localparam logic [EV_W-1:0] EV_PAYLOAD  = 2'd0;
	localparam logic [EV_W-1:0] EV_EMPTY    = 2'd1;
	localparam logic [EV_W-1:0] EV_BAD_CRC  = 2'd2;
	localparam logic [EV_W-1:0] EV_OVERRUN  = 2'd3;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED = 1'd1;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
	localparam logic [BYTE_W-1:0] CRC_MSB  = 8'h80;

	// CRC-8, MSB first, one byte
	function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] v;
		v = crc ^ b;
		for (int k = 0; k < BYTE_W; k++) begin
			if ((v & CRC_MSB) != '0)
				v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			else
				v = {v[BYTE_W-2:0], 1'b0};
		end
		return v;
	endfunction

endpackage

// File: hw/rtl/crc8fr_rx_if.sv
`timescale 1ns / 1ps

interface crc8fr_rx_if;
	logic                          valid;
	logic                          ready;
	logic [crc8fr_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// File: hw/rtl/crc8fr_res_if.sv
`timescale 1ns / 1ps

interface crc8fr_res_if;
	logic                          valid;
	logic                          ready;
	logic [crc8fr_pkg::EV_W-1:0]   event_res;
	logic [crc8fr_pkg::BYTE_W-1:0] frame_type;
	logic [crc8fr_pkg::BYTE_W-1:0] frame_len;
	logic [crc8fr_pkg::IDX_W-1:0]  byte_index;
	logic [crc8fr_pkg::BYTE_W-1:0] payload_byte;
	logic                          last;
	logic [crc8fr_pkg::CNT_W-1:0]  count_bytes;
	logic [crc8fr_pkg::CNT_W-1:0]  count_bad_sync;
	logic [crc8fr_pkg::CNT_W-1:0]  count_overruns;
	logic [crc8fr_pkg::CNT_W-1:0]  count_good;
	logic [crc8fr_pkg::CNT_W-1:0]  count_bad_crc;

	modport source (output valid, output event_res, output frame_type, output frame_len,
		output byte_index, output payload_byte, output last, output count_bytes,
		output count_bad_sync, output count_overruns, output count_good,
		output count_bad_crc, input ready);
	modport sink (input valid, input event_res, input frame_type, input frame_len,
		input byte_index, input payload_byte, input last, input count_bytes,
		input count_bad_sync, input count_overruns, input count_good,
		input count_bad_crc, output ready);
endinterface

// File: hw/rtl/crc8_frame_receiver.sv
`timescale 1ns / 1ps

// CRC-8 framed packet receiver.
// rx carries one received byte per beat. res carries results: payload bytes
// of a good frame (last marks the final one), a good-empty-frame event, a
// bad-CRC event or a length-overrun event, each with a snapshot of the five
// counters taken after the causing byte is counted.
// cfg_we/cfg_idx/cfg_data write sync_byte (index 0) and crc_seed (index 1).
// Header and payload bytes are taken one per cycle and give no result; the
// CRC runs one byte per cycle alongside. An event result is in the output
// register in the cycle after its byte is taken. The payload bytes of a good
// frame are replayed from the payload RAM, each through a RAM read state
// and then an output load state; rx is held off during the replay.
// A length or CRC byte is taken only when the output register is free or
// being drained; while res is stalled outside a replay, other bytes keep
// flowing in.
// Reset returns to sync hunting and clears counters and configuration; the
// payload RAM is not cleared, only bytes written in the current frame are read.
module crc8_frame_receiver #(
	parameter int MAX_PAYLOAD = crc8fr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [crc8fr_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [crc8fr_pkg::BYTE_W-1:0]       cfg_data,
	crc8fr_rx_if.sink                           rx,
	crc8fr_res_if.source                        res
);

	localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int LW = $clog2(MAX_PAYLOAD + 1);

	localparam logic [2:0] PH_HUNT  = 3'd0;
	localparam logic [2:0] PH_TYPE  = 3'd1;
	localparam logic [2:0] PH_LEN   = 3'd2;
	localparam logic [2:0] PH_DATA  = 3'd3;
	localparam logic [2:0] PH_CHECK = 3'd4;
	localparam logic [2:0] PH_RD    = 3'd5;
	localparam logic [2:0] PH_OUT   = 3'd6;
	localparam logic [2:0] PH_SPARE = 3'd7;

	localparam int BW = crc8fr_pkg::BYTE_W;
	localparam int CW = crc8fr_pkg::CNT_W;

	logic [BW-1:0] sync_q, seed_q;
	logic [2:0]    phase_q;
	logic [BW-1:0] type_q, crc_q;
	logic [LW-1:0] len_q, fill_q;
	logic [IW-1:0] rd_idx_q;
	logic [CW-1:0] bytes_q, bad_sync_q, ovr_q, good_q, bad_crc_q;

	logic [BW-1:0] mem [MAX_PAYLOAD];
	logic [BW-1:0] rd_data_s1;

	logic          out_valid_q;
	logic [crc8fr_pkg::EV_W-1:0]  out_ev_q;
	logic [BW-1:0] out_type_q, out_len_q, out_data_q;
	logic [crc8fr_pkg::IDX_W-1:0] out_idx_q;
	logic          out_last_q;
	logic [CW-1:0] out_bytes_q, out_bad_sync_q, out_ovr_q, out_good_q, out_bad_crc_q;

	logic          out_free, in_rdy, accept;
	logic [BW-1:0] b, crc_nx;
	logic          is_hunt, sync_hit, len_ovr, crc_ok, good_full, evt_load, rep_load;
	logic          rep_last;
	logic [LW-1:0] fill_inc;
	logic [CW-1:0] bytes_nx, bad_sync_nx, ovr_nx, good_nx, bad_crc_nx;

	assign b        = rx.rx_byte;
	assign out_free = !out_valid_q || res.ready;
	assign in_rdy   = (phase_q != PH_RD) && (phase_q != PH_OUT) &&
		(((phase_q != PH_LEN) && (phase_q != PH_CHECK)) || out_free);
	assign accept   = rx.valid && in_rdy;
	assign rx.ready = in_rdy;

	assign is_hunt   = (phase_q == PH_HUNT) || (phase_q == PH_SPARE);
	assign sync_hit  = (b == sync_q);
	assign len_ovr   = (phase_q == PH_LEN) && (b > BW'(MAX_PAYLOAD));
	assign crc_ok    = (crc_q == b);
	assign good_full = (phase_q == PH_CHECK) && crc_ok && (len_q != '0);
	assign evt_load  = accept && (len_ovr || ((phase_q == PH_CHECK) && !good_full));
	assign rep_load  = (phase_q == PH_OUT) && out_free;
	assign rep_last  = ((LW'(rd_idx_q) + LW'(1)) == len_q);
	assign crc_nx    = crc8fr_pkg::crc8_update(crc_q, b);
	assign fill_inc  = fill_q + LW'(1);

	// counter values after the current byte is counted
	assign bytes_nx    = bytes_q + CW'(1);
	assign bad_sync_nx = bad_sync_q + CW'(is_hunt && !sync_hit);
	assign ovr_nx      = ovr_q + CW'(len_ovr);
	assign good_nx     = good_q + CW'((phase_q == PH_CHECK) && crc_ok);
	assign bad_crc_nx  = bad_crc_q + CW'((phase_q == PH_CHECK) && !crc_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= '0;
			seed_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				crc8fr_pkg::CFG_SYNC: sync_q <= cfg_data;
				crc8fr_pkg::CFG_SEED: seed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			type_q     <= '0;
			len_q      <= '0;
			fill_q     <= '0;
			crc_q      <= '0;
			rd_idx_q   <= '0;
			bytes_q    <= '0;
			bad_sync_q <= '0;
			ovr_q      <= '0;
			good_q     <= '0;
			bad_crc_q  <= '0;
		end else begin
			if (accept) begin
				bytes_q    <= bytes_nx;
				bad_sync_q <= bad_sync_nx;
				ovr_q      <= ovr_nx;
				good_q     <= good_nx;
				bad_crc_q  <= bad_crc_nx;
				case (phase_q)
					PH_TYPE: begin
						type_q  <= b;
						crc_q   <= crc_nx;
						phase_q <= PH_LEN;
					end
					PH_LEN: begin
						fill_q <= '0;
						if (len_ovr) begin
							phase_q <= PH_HUNT;
						end else begin
							len_q   <= b[LW-1:0];
							crc_q   <= crc_nx;
							phase_q <= (b == '0) ? PH_CHECK : PH_DATA;
						end
					end
					PH_DATA: begin
						crc_q  <= crc_nx;
						fill_q <= fill_inc;
						if (fill_inc >= len_q)
							phase_q <= PH_CHECK;
					end
					PH_CHECK: begin
						fill_q   <= '0;
						rd_idx_q <= '0;
						phase_q  <= good_full ? PH_RD : PH_HUNT;
					end
					default: begin
						if (sync_hit) begin
							crc_q   <= seed_q;
							phase_q <= PH_TYPE;
						end else begin
							phase_q <= PH_HUNT;
						end
					end
				endcase
			end else if (phase_q == PH_RD) begin
				phase_q <= PH_OUT;
			end else if (rep_load) begin
				if (rep_last) begin
					phase_q <= PH_HUNT;
				end else begin
					rd_idx_q <= rd_idx_q + IW'(1);
					phase_q  <= PH_RD;
				end
			end
		end
	end

	// payload RAM: written while filling, read only during replay
	always_ff @(posedge clk) begin
		if (accept && (phase_q == PH_DATA))
			mem[fill_q[IW-1:0]] <= b;
		if (phase_q == PH_RD)
			rd_data_s1 <= mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (evt_load || rep_load)
			out_valid_q <= 1'b1;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (evt_load) begin
			out_ev_q       <= len_ovr ? crc8fr_pkg::EV_OVERRUN :
				(crc_ok ? crc8fr_pkg::EV_EMPTY : crc8fr_pkg::EV_BAD_CRC);
			out_type_q     <= len_ovr ? '0 : type_q;
			out_len_q      <= len_ovr ? b : BW'(len_q);
			out_idx_q      <= '0;
			out_data_q     <= '0;
			out_last_q     <= 1'b1;
			out_bytes_q    <= bytes_nx;
			out_bad_sync_q <= bad_sync_nx;
			out_ovr_q      <= ovr_nx;
			out_good_q     <= good_nx;
			out_bad_crc_q  <= bad_crc_nx;
		end else if (rep_load) begin
			out_ev_q       <= crc8fr_pkg::EV_PAYLOAD;
			out_type_q     <= type_q;
			out_len_q      <= BW'(len_q);
			out_idx_q      <= crc8fr_pkg::IDX_W'(rd_idx_q);
			out_data_q     <= rd_data_s1;
			out_last_q     <= rep_last;
			out_bytes_q    <= bytes_q;
			out_bad_sync_q <= bad_sync_q;
			out_ovr_q      <= ovr_q;
			out_good_q     <= good_q;
			out_bad_crc_q  <= bad_crc_q;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.event_res      = out_ev_q;
	assign res.frame_type     = out_type_q;
	assign res.frame_len      = out_len_q;
	assign res.byte_index     = out_idx_q;
	assign res.payload_byte   = out_data_q;
	assign res.last           = out_last_q;
	assign res.count_bytes    = out_bytes_q;
	assign res.count_bad_sync = out_bad_sync_q;
	assign res.count_overruns = out_ovr_q;
	assign res.count_good     = out_good_q;
	assign res.count_bad_crc  = out_bad_crc_q;

endmodule

// File: hw/rtl/crc8fr_checker.sv
`timescale 1ns / 1ps

module crc8fr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              rx_valid,
	input logic                              rx_ready,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic [crc8fr_pkg::EV_W-1:0]       res_event_res,
	input logic [crc8fr_pkg::BYTE_W-1:0]     res_payload_byte,
	input logic                              res_last
);

	// a stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_event_res) &&
		$stable(res_payload_byte) && $stable(res_last))
		else $error("result beat changed while stalled");

	// input is held off while a frame replay is in progress
	a_replay_blocks_rx: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_event_res == crc8fr_pkg::EV_PAYLOAD) && !res_last |-> !rx_ready)
		else $error("rx taken during payload replay");

	// taking a byte never drops a result that is still waiting
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid && rx_ready && res_valid && !res_ready |=> res_valid)
		else $error("pending result lost on rx beat");

endmodule

bind crc8_frame_receiver crc8fr_checker u_crc8fr_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rx_valid         (rx.valid),
	.rx_ready         (rx.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_event_res    (res.event_res),
	.res_payload_byte (res.payload_byte),
	.res_last         (res.last)
);
